// ----- hw/rtl/tcls_pkg.sv -----
`timescale 1ns / 1ps
package tcls_pkg;

	// Default sampling window in ticks
	localparam int unsigned LOAD_WINDOW_DEF = 100;

	// Wall clock rollover
	localparam int unsigned USEC_PER_SEC = 1000000;

	// Depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Configuration port
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [1:0] REG_CLK_INC          = 2'd0;
	localparam logic [1:0] REG_USEC_INC         = 2'd1;
	localparam logic [1:0] REG_QUANTUM_PER_TICK = 2'd2;

	localparam logic [15:0] CLK_INC_RST          = 16'd11931;
	localparam logic [19:0] USEC_INC_RST         = 20'd10000;
	localparam logic [7:0]  QUANTUM_PER_TICK_RST = 8'd1;

	// Request function codes
	localparam logic FUNC_TICK     = 1'b0;
	localparam logic FUNC_SET_TIME = 1'b1;

	// Tick classes as stored in the ring
	typedef enum logic [1:0] {
		CLS_IDLE   = 2'd0,
		CLS_USER   = 2'd1,
		CLS_KERNEL = 2'd2,
		CLS_DPC    = 2'd3
	} cls_t;

	// Where the tick time is charged
	localparam logic [1:0] CHG_NONE   = 2'd0;
	localparam logic [1:0] CHG_DPC    = 2'd1;
	localparam logic [1:0] CHG_USER   = 2'd2;
	localparam logic [1:0] CHG_SYSTEM = 2'd3;

	// Classified request passed from front to back
	typedef struct packed {
		logic               func;
		cls_t               cls;
		logic [1:0]         charged;
		logic signed [31:0] quantum;
		logic               preempt;
		logic [31:0]        new_seconds;
		logic [19:0]        new_microseconds;
	} item_t;

endpackage

// ----- hw/rtl/tcls_ram.sv -----
`timescale 1ns / 1ps
module tcls_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- hw/rtl/tcls_front.sv -----
`timescale 1ns / 1ps
module tcls_front (
	input  logic                func,
	input  logic                in_dpc,
	input  logic                user_mode,
	input  logic                idle_thread,
	input  logic signed [31:0]  quantum_in,
	input  logic [31:0]         new_seconds,
	input  logic [19:0]         new_microseconds,
	input  logic [7:0]          quantum_per_tick,
	output tcls_pkg::item_t     item
);
	import tcls_pkg::*;

	logic signed [32:0] q_diff;
	logic signed [31:0] q_sat;

	// Charge the quantum, saturating at the most negative value
	always_comb begin
		q_diff = {quantum_in[31], quantum_in} - $signed({25'd0, quantum_per_tick});
		if (q_diff[32:31] == 2'b10) begin
			q_sat = {1'b1, 31'd0};
		end else begin
			q_sat = q_diff[31:0];
		end
	end

	// Classify: dpc, then user, then idle or kernel
	always_comb begin
		item.func             = func;
		item.new_seconds      = new_seconds;
		item.new_microseconds = new_microseconds;
		item.cls              = CLS_IDLE;
		item.charged          = CHG_NONE;
		item.quantum          = '0;
		item.preempt          = 1'b0;
		if (func == FUNC_TICK) begin
			item.quantum = q_sat;
			item.preempt = (q_sat <= 0);
			if (in_dpc) begin
				item.cls     = CLS_DPC;
				item.charged = CHG_DPC;
			end else if (user_mode) begin
				item.cls     = CLS_USER;
				item.charged = CHG_USER;
			end else begin
				item.cls     = idle_thread ? CLS_IDLE : CLS_KERNEL;
				item.charged = CHG_SYSTEM;
			end
		end
	end
endmodule

// ----- hw/rtl/tcls_fifo.sv -----
`timescale 1ns / 1ps
module tcls_fifo #(
	parameter int unsigned DEPTH = tcls_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tcls_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output tcls_pkg::item_t pop_item
);
	import tcls_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ----- hw/rtl/tcls_back.sv -----
`timescale 1ns / 1ps
module tcls_back #(
	parameter int unsigned LOAD_WINDOW = tcls_pkg::LOAD_WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  tcls_pkg::item_t    item,
	output logic               pop,
	input  logic [15:0]        clk_inc,
	input  logic [19:0]        usec_inc,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        seconds,
	output logic [19:0]        microseconds,
	output logic [31:0]        tick_count,
	output logic [31:0]        clock_count,
	output logic [31:0]        uptime_seconds,
	output logic [6:0]         user_load,
	output logic [6:0]         load_kernel,
	output logic [6:0]         load_dpc,
	output logic [6:0]         idle_load,
	output logic signed [31:0] quantum_out,
	output logic               preempt,
	output logic [1:0]         charged_to
);
	import tcls_pkg::*;

	localparam int unsigned POS_W = $clog2(LOAD_WINDOW);
	localparam int unsigned CNT_W = $clog2(LOAD_WINDOW + 1);
	localparam int unsigned EXT_W = (CNT_W > 7) ? CNT_W : 7;

	function automatic logic [6:0] sat7(input logic [CNT_W-1:0] v);
		logic [EXT_W-1:0] e;
		e = EXT_W'(v);
		return (e > EXT_W'(127)) ? 7'd127 : e[6:0];
	endfunction

	// Clock and counter state
	logic [31:0]      wall_s_q;
	logic [19:0]      wall_us_q;
	logic [31:0]      start_s_q;
	logic [31:0]      ticks_q;
	logic [31:0]      clocks_q;
	logic [POS_W-1:0] pos_q;
	logic             wrapped_q;
	logic [CNT_W-1:0] cnt_q [4];

	// Output register
	logic               out_valid_q;
	logic [31:0]        seconds_q;
	logic [19:0]        microseconds_q;
	logic [31:0]        tick_count_q;
	logic [31:0]        clock_count_q;
	logic [31:0]        uptime_q;
	logic [6:0]         user_load_q;
	logic [6:0]         load_kernel_q;
	logic [6:0]         load_dpc_q;
	logic [6:0]         idle_load_q;
	logic signed [31:0] quantum_q;
	logic               preempt_q;
	logic [1:0]         charged_q;

	logic             fire;
	logic             tick;
	logic [POS_W-1:0] pos_next;
	logic [POS_W-1:0] ring_raddr;
	logic [1:0]       ring_rdata;
	cls_t             old_cls;
	logic [20:0]      usum;
	logic [19:0]      us_n;
	logic [1:0]       sec_inc;
	logic [31:0]      wall_s_n;
	logic [CNT_W-1:0] cnt_n [4];

	assign fire = item_valid && (!out_valid_q || !out_stall);
	assign pop  = fire;
	assign tick = fire && (item.func == FUNC_TICK);

	// Ring position; the read runs one slot ahead so the old class is ready
	assign pos_next   = (pos_q == POS_W'(LOAD_WINDOW - 1)) ? '0 : pos_q + 1'b1;
	assign ring_raddr = tick ? pos_next : pos_q;

	tcls_ram #(
		.WIDTH(2),
		.DEPTH(LOAD_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (tick),
		.waddr(pos_q),
		.wdata(item.cls),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	// Slots not yet written on the first pass hold idle
	assign old_cls = wrapped_q ? cls_t'(ring_rdata) : CLS_IDLE;

	// Microsecond add with up to two carries into seconds
	always_comb begin
		usum = {1'b0, wall_us_q} + {1'b0, usec_inc};
		if (usum >= 21'(2 * USEC_PER_SEC)) begin
			us_n    = 20'(usum - 21'(2 * USEC_PER_SEC));
			sec_inc = 2'd2;
		end else if (usum >= 21'(USEC_PER_SEC)) begin
			us_n    = 20'(usum - 21'(USEC_PER_SEC));
			sec_inc = 2'd1;
		end else begin
			us_n    = usum[19:0];
			sec_inc = 2'd0;
		end
		wall_s_n = wall_s_q + {30'd0, sec_inc};
	end

	// Running class counts: drop the overwritten slot, add the new one
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			cnt_n[c] = cnt_q[c];
			if (item.cls == cls_t'(c)) begin
				cnt_n[c] = cnt_n[c] + 1'b1;
			end
			if (old_cls == cls_t'(c)) begin
				cnt_n[c] = cnt_n[c] - 1'b1;
			end
		end
	end

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_s_q  <= '0;
			wall_us_q <= '0;
			start_s_q <= '0;
			ticks_q   <= '0;
			clocks_q  <= '0;
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			cnt_q[CLS_IDLE]   <= CNT_W'(LOAD_WINDOW);
			cnt_q[CLS_USER]   <= '0;
			cnt_q[CLS_KERNEL] <= '0;
			cnt_q[CLS_DPC]    <= '0;
		end else if (fire) begin
			if (item.func == FUNC_SET_TIME) begin
				start_s_q <= start_s_q + (item.new_seconds - wall_s_q);
				wall_s_q  <= item.new_seconds;
				wall_us_q <= item.new_microseconds;
			end else begin
				wall_s_q  <= wall_s_n;
				wall_us_q <= us_n;
				ticks_q   <= ticks_q + 32'd1;
				clocks_q  <= clocks_q + {16'd0, clk_inc};
				pos_q     <= pos_next;
				if (pos_q == POS_W'(LOAD_WINDOW - 1)) begin
					wrapped_q <= 1'b1;
				end
				for (int c = 0; c < 4; c++) begin
					cnt_q[c] <= cnt_n[c];
				end
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (fire) begin
			quantum_q <= item.quantum;
			preempt_q <= item.preempt;
			charged_q <= item.charged;
			tick_count_q <= (item.func == FUNC_TICK) ? ticks_q + 32'd1 : ticks_q;
			clock_count_q <= (item.func == FUNC_TICK) ?
				clocks_q + {16'd0, clk_inc} : clocks_q;
			if (item.func == FUNC_SET_TIME) begin
				seconds_q      <= item.new_seconds;
				microseconds_q <= item.new_microseconds;
				uptime_q       <= wall_s_q - start_s_q;
				user_load_q    <= sat7(cnt_q[CLS_USER]);
				load_kernel_q  <= sat7(cnt_q[CLS_KERNEL]);
				load_dpc_q     <= sat7(cnt_q[CLS_DPC]);
				idle_load_q    <= sat7(cnt_q[CLS_IDLE]);
			end else begin
				seconds_q      <= wall_s_n;
				microseconds_q <= us_n;
				uptime_q       <= wall_s_n - start_s_q;
				user_load_q    <= sat7(cnt_n[CLS_USER]);
				load_kernel_q  <= sat7(cnt_n[CLS_KERNEL]);
				load_dpc_q     <= sat7(cnt_n[CLS_DPC]);
				idle_load_q    <= sat7(cnt_n[CLS_IDLE]);
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign seconds        = seconds_q;
	assign microseconds   = microseconds_q;
	assign tick_count     = tick_count_q;
	assign clock_count    = clock_count_q;
	assign uptime_seconds = uptime_q;
	assign user_load      = user_load_q;
	assign load_kernel    = load_kernel_q;
	assign load_dpc       = load_dpc_q;
	assign idle_load      = idle_load_q;
	assign quantum_out    = quantum_q;
	assign preempt        = preempt_q;
	assign charged_to     = charged_q;
endmodule

// ----- hw/rtl/tick_clock_and_load_sampler.sv -----
`timescale 1ns / 1ps
// Path: an accepted request waits in the queue, then the back end registers its result.
// Throughput: one request per cycle while out_stall is low; the back end does its whole
// update per request (ring read one slot ahead, running class counts, wall clock carry).
// Reset: arst_n clears clocks, counters and queue; class counts start with idle at the
// full window. Ring slots are tracked by a first-pass flag, so no clearing pass is run.
module tick_clock_and_load_sampler #(
	parameter int unsigned LOAD_WINDOW = tcls_pkg::LOAD_WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcls_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [tcls_pkg::APB_DATA_W-1:0] pwdata,
	output logic [tcls_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic                            in_dpc,
	input  logic                            user_mode,
	input  logic                            idle_thread,
	input  logic signed [31:0]              quantum_in,
	input  logic [31:0]                     new_seconds,
	input  logic [19:0]                     new_microseconds,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [31:0]                     seconds,
	output logic [19:0]                     microseconds,
	output logic [31:0]                     tick_count,
	output logic [31:0]                     clock_count,
	output logic [31:0]                     uptime_seconds,
	output logic [6:0]                      user_load,
	output logic [6:0]                      load_kernel,
	output logic [6:0]                      load_dpc,
	output logic [6:0]                      idle_load,
	output logic signed [31:0]              quantum_out,
	output logic                            preempt,
	output logic [1:0]                      charged_to
);
	import tcls_pkg::*;

	logic [15:0] clk_inc_q;
	logic [19:0] usec_inc_q;
	logic [7:0]  quantum_per_tick_q;
	logic [1:0]  reg_idx;
	logic        reg_wr;
	item_t       front_item;
	item_t       back_item;
	logic        q_full;
	logic        q_not_empty;
	logic        q_pop;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_inc_q          <= CLK_INC_RST;
			usec_inc_q         <= USEC_INC_RST;
			quantum_per_tick_q <= QUANTUM_PER_TICK_RST;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_CLK_INC:          clk_inc_q          <= pwdata[15:0];
				REG_USEC_INC:         usec_inc_q         <= pwdata[19:0];
				REG_QUANTUM_PER_TICK: quantum_per_tick_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CLK_INC:          prdata = {16'd0, clk_inc_q};
			REG_USEC_INC:         prdata = {12'd0, usec_inc_q};
			REG_QUANTUM_PER_TICK: prdata = {24'd0, quantum_per_tick_q};
			default:              prdata = '0;
		endcase
	end

	// Front: classify and charge quantum
	tcls_front u_front (
		.func            (func),
		.in_dpc          (in_dpc),
		.user_mode       (user_mode),
		.idle_thread     (idle_thread),
		.quantum_in      (quantum_in),
		.new_seconds     (new_seconds),
		.new_microseconds(new_microseconds),
		.quantum_per_tick(quantum_per_tick_q),
		.item            (front_item)
	);

	assign in_stall = q_full;

	// Queue between front and back
	tcls_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_item(front_item),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.pop_item (back_item)
	);

	// Back: clocks, ring and result register
	tcls_back #(
		.LOAD_WINDOW(LOAD_WINDOW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (q_not_empty),
		.item           (back_item),
		.pop            (q_pop),
		.clk_inc        (clk_inc_q),
		.usec_inc       (usec_inc_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.seconds        (seconds),
		.microseconds   (microseconds),
		.tick_count     (tick_count),
		.clock_count    (clock_count),
		.uptime_seconds (uptime_seconds),
		.user_load      (user_load),
		.load_kernel    (load_kernel),
		.load_dpc       (load_dpc),
		.idle_load      (idle_load),
		.quantum_out    (quantum_out),
		.preempt        (preempt),
		.charged_to     (charged_to)
	);
endmodule

// ----- hw/rtl/tcls_checker.sv -----
`timescale 1ns / 1ps
module tcls_checker #(
	parameter int unsigned LOAD_WINDOW = tcls_pkg::LOAD_WINDOW_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [31:0]        seconds,
	input logic [31:0]        tick_count,
	input logic [6:0]         user_load,
	input logic [6:0]         load_kernel,
	input logic [6:0]         load_dpc,
	input logic [6:0]         idle_load,
	input logic signed [31:0] quantum_out,
	input logic               preempt,
	input logic [1:0]         charged_to
);
	import tcls_pkg::*;

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(seconds) && $stable(tick_count))
		else $error("stalled result changed");

	// Set-time results charge nothing
	a_set_time_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (charged_to == CHG_NONE) |-> (quantum_out == 0) && !preempt)
		else $error("set-time result carries quantum");

	// Preempt follows the charged quantum
	a_preempt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (charged_to != CHG_NONE) |-> preempt == (quantum_out <= 0))
		else $error("preempt does not match quantum");

	// Class counts cover the whole window
	if (LOAD_WINDOW <= 127) begin : g_sum
		a_load_sum: assert property (@(posedge clk) disable iff (!arst_n)
			out_valid |-> ({2'd0, user_load} + {2'd0, load_kernel} + {2'd0, load_dpc}
				+ {2'd0, idle_load}) == 9'(LOAD_WINDOW))
			else $error("load counts do not sum to window");
	end
endmodule

bind tick_clock_and_load_sampler tcls_checker #(
	.LOAD_WINDOW(LOAD_WINDOW)
) u_tcls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.seconds    (seconds),
	.tick_count (tick_count),
	.user_load  (user_load),
	.load_kernel(load_kernel),
	.load_dpc   (load_dpc),
	.idle_load  (idle_load),
	.quantum_out(quantum_out),
	.preempt    (preempt),
	.charged_to (charged_to)
);

// ----- verif/tick_clock_and_load_sampler_checker.sv -----
`timescale 1ns / 1ps
module tick_clock_and_load_sampler_checker #(
	parameter int unsigned LOAD_WINDOW = tcls_pkg::LOAD_WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcls_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [tcls_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [tcls_pkg::APB_DATA_W-1:0] prdata,
	input  logic                            pready,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            func,
	input  logic                            in_dpc,
	input  logic                            user_mode,
	input  logic                            idle_thread,
	input  logic signed [31:0]              quantum_in,
	input  logic [31:0]                     new_seconds,
	input  logic [19:0]                     new_microseconds,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [31:0]                     seconds,
	input  logic [19:0]                     microseconds,
	input  logic [31:0]                     tick_count,
	input  logic [31:0]                     clock_count,
	input  logic [31:0]                     uptime_seconds,
	input  logic [6:0]                      user_load,
	input  logic [6:0]                      load_kernel,
	input  logic [6:0]                      load_dpc,
	input  logic [6:0]                      idle_load,
	input  logic signed [31:0]              quantum_out,
	input  logic                            preempt,
	input  logic [1:0]                      charged_to,
	output int                              failures,
	output int                              outstanding
);
	import tcls_pkg::*;

	localparam longint QUANTUM_MIN = -64'sd2147483648;

	// Expected state of the clock and load sampler after one request
	typedef struct {
		logic [31:0]        seconds;
		logic [19:0]        microseconds;
		logic [31:0]        ticks;
		logic [31:0]        clocks;
		logic [31:0]        uptime;
		logic [6:0]         user;
		logic [6:0]         kernel;
		logic [6:0]         dpc;
		logic [6:0]         idle;
		logic signed [31:0] quantum;
		logic               preempt;
		logic [1:0]         charged;
	} reading_t;

	reading_t pending_readings[$];

	// Register copies
	logic [15:0] cfg_clocks;
	logic [19:0] cfg_usecs;
	logic [7:0]  cfg_quantum;

	// Mirror of the sampler state
	cls_t        tick_ring[LOAD_WINDOW];
	int unsigned ring_slot;
	int unsigned class_count[4];
	logic [31:0] wall_sec;
	logic [19:0] wall_usec;
	logic [31:0] tick_total;
	logic [31:0] clock_total;
	logic [31:0] start_sec;

	function automatic logic [6:0] sat7(int unsigned v);
		return (v > 127) ? 7'd127 : v[6:0];
	endfunction

	task automatic compare_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		reading_t    want;
		cls_t        cls;
		longint      charged_q;
		logic [20:0] usec_sum;
		if (!arst_n) begin
			cfg_clocks  = CLK_INC_RST;
			cfg_usecs   = USEC_INC_RST;
			cfg_quantum = QUANTUM_PER_TICK_RST;
			foreach (tick_ring[k])
				tick_ring[k] = CLS_IDLE;
			ring_slot = 0;
			class_count[CLS_IDLE]   = LOAD_WINDOW;
			class_count[CLS_USER]   = 0;
			class_count[CLS_KERNEL] = 0;
			class_count[CLS_DPC]    = 0;
			wall_sec    = '0;
			wall_usec   = '0;
			tick_total  = '0;
			clock_total = '0;
			start_sec   = '0;
			failures    = 0;
			pending_readings.delete();
			outstanding <= 0;
		end else begin
			// register writes and readback
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[APB_ADDR_W-1:2])
						REG_CLK_INC:          cfg_clocks  = pwdata[15:0];
						REG_USEC_INC:         cfg_usecs   = pwdata[19:0];
						REG_QUANTUM_PER_TICK: cfg_quantum = pwdata[7:0];
						default: ;
					endcase
				end else begin
					case (paddr[APB_ADDR_W-1:2])
						REG_CLK_INC:          compare_field("prdata", cfg_clocks, prdata);
						REG_USEC_INC:         compare_field("prdata", cfg_usecs, prdata);
						REG_QUANTUM_PER_TICK: compare_field("prdata", cfg_quantum, prdata);
						default: ;
					endcase
				end
			end

			// result side: oldest expectation first
			if (out_valid && !out_stall) begin
				if (pending_readings.size() == 0) begin
					$error("result with no request outstanding");
					failures++;
				end else begin
					want = pending_readings.pop_front();
					compare_field("seconds", want.seconds, seconds);
					compare_field("microseconds", want.microseconds, microseconds);
					compare_field("tick_count", want.ticks, tick_count);
					compare_field("clock_count", want.clocks, clock_count);
					compare_field("uptime_seconds", want.uptime, uptime_seconds);
					compare_field("user_load", want.user, user_load);
					compare_field("load_kernel", want.kernel, load_kernel);
					compare_field("load_dpc", want.dpc, load_dpc);
					compare_field("idle_load", want.idle, idle_load);
					compare_field("quantum_out", longint'(want.quantum), longint'(quantum_out));
					compare_field("preempt", want.preempt, preempt);
					compare_field("charged_to", want.charged, charged_to);
				end
			end

			// request side: advance the mirror
			if (in_valid && !in_stall) begin
				if (func == FUNC_SET_TIME) begin
					// uptime is kept by moving the start time along
					start_sec    = start_sec + (new_seconds - wall_sec);
					wall_sec     = new_seconds;
					wall_usec    = new_microseconds;
					want.quantum = '0;
					want.preempt = 1'b0;
					want.charged = CHG_NONE;
				end else begin
					clock_total = clock_total + cfg_clocks;
					tick_total  = tick_total + 32'd1;
					usec_sum    = {1'b0, wall_usec} + {1'b0, cfg_usecs};
					while (usec_sum >= 21'(USEC_PER_SEC)) begin
						usec_sum = usec_sum - 21'(USEC_PER_SEC);
						wall_sec = wall_sec + 32'd1;
					end
					wall_usec = usec_sum[19:0];

					// dpc beats user beats idle/kernel
					if (in_dpc) begin
						cls          = CLS_DPC;
						want.charged = CHG_DPC;
					end else if (user_mode) begin
						cls          = CLS_USER;
						want.charged = CHG_USER;
					end else begin
						cls          = idle_thread ? CLS_IDLE : CLS_KERNEL;
						want.charged = CHG_SYSTEM;
					end

					// replace the oldest slot of the window
					class_count[tick_ring[ring_slot]]--;
					tick_ring[ring_slot] = cls;
					class_count[cls]++;
					ring_slot = (ring_slot + 1 == LOAD_WINDOW) ? 0 : ring_slot + 1;

					// quantum charge, saturating low
					charged_q = longint'(quantum_in) - longint'(cfg_quantum);
					if (charged_q < QUANTUM_MIN)
						charged_q = QUANTUM_MIN;
					want.quantum = charged_q[31:0];
					want.preempt = (charged_q <= 0);
				end
				want.seconds      = wall_sec;
				want.microseconds = wall_usec;
				want.ticks        = tick_total;
				want.clocks       = clock_total;
				want.uptime       = wall_sec - start_sec;
				want.user         = sat7(class_count[CLS_USER]);
				want.kernel       = sat7(class_count[CLS_KERNEL]);
				want.dpc          = sat7(class_count[CLS_DPC]);
				want.idle         = sat7(class_count[CLS_IDLE]);
				pending_readings.push_back(want);
			end
			outstanding <= pending_readings.size();
		end
	end

endmodule

// ----- verif/tick_clock_and_load_sampler_tb.sv -----
`timescale 1ns / 1ps
module tick_clock_and_load_sampler_tb;
	import tcls_pkg::*;

	localparam logic [1:0] REG_UNUSED     = 2'd3;
	localparam int         HOLD_OFF_CYCLES = 400;
	localparam int         WATCHDOG_LIMIT  = 5000;
	localparam int         PHASES          = 8;
	localparam int         PHASE_REQUESTS  = 190;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	logic                  func;
	logic                  in_dpc;
	logic                  user_mode;
	logic                  idle_thread;
	logic signed [31:0]    quantum_in;
	logic [31:0]           new_seconds;
	logic [19:0]           new_microseconds;
	logic                  out_valid;
	logic                  out_stall;
	logic [31:0]           seconds;
	logic [19:0]           microseconds;
	logic [31:0]           tick_count;
	logic [31:0]           clock_count;
	logic [31:0]           uptime_seconds;
	logic [6:0]            user_load;
	logic [6:0]            load_kernel;
	logic [6:0]            load_dpc;
	logic [6:0]            idle_load;
	logic signed [31:0]    quantum_out;
	logic                  preempt;
	logic [1:0]            charged_to;
	int                    failures;
	int                    outstanding;

	logic hold_off_req;
	int   burst_left;
	int   quiet_cycles = 0;

	tick_clock_and_load_sampler uut (.*);

	tick_clock_and_load_sampler_checker chk (.*);

	always #5 clk = ~clk;

	// one APB access, setup then access phase
	task automatic apb(input logic wr, input logic [1:0] idx, input logic [31:0] data);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = {idx, 2'b00};
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// stop offering and wait for every result to come back
	task automatic drain();
		in_valid = 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	// reconfigure while idle; upper bits carry junk that must be masked
	task automatic configure(input logic [15:0] cpt, input logic [19:0] upt,
			input logic [7:0] qpt);
		logic [31:0] junk;
		drain();
		junk = $urandom;
		apb(1'b1, REG_CLK_INC, {junk[15:0], cpt});
		apb(1'b1, REG_USEC_INC, {junk[31:20], upt});
		apb(1'b1, REG_QUANTUM_PER_TICK, {junk[23:0], qpt});
		apb(1'b1, REG_UNUSED, $urandom);
		apb(1'b0, REG_CLK_INC, '0);
		apb(1'b0, REG_USEC_INC, '0);
		apb(1'b0, REG_QUANTUM_PER_TICK, '0);
	endtask

	// offer one request, hold it until taken, then maybe close the burst
	task automatic offer(input logic f, input logic d, input logic u, input logic i,
			input logic [31:0] q, input logic [31:0] s, input logic [19:0] us);
		int gap;
		in_valid         = 1'b1;
		func             = f;
		in_dpc           = d;
		user_mode        = u;
		idle_thread      = i;
		quantum_in       = q;
		new_seconds      = s;
		new_microseconds = us;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// random request; steer forces a tick of the target class
	task automatic random_request(input bit steer, input cls_t target);
		logic        d;
		logic        u;
		logic        i;
		logic [31:0] q;
		logic [31:0] s;
		logic [19:0] us;
		d = 1'($urandom_range(0, 1));
		u = 1'($urandom_range(0, 1));
		i = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0: q = $urandom;
			1: q = $urandom_range(0, 600) - 300;
			2: q = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 + $urandom_range(0, 300)
					: 32'h7FFF_FFFF - $urandom_range(0, 300);
			default: q = $urandom_range(0, 300);
		endcase
		case ($urandom_range(0, 2))
			0: s = $urandom;
			1: s = $urandom_range(0, 100);
			default: s = 32'hFFFF_FFFF - $urandom_range(0, 100);
		endcase
		us = ($urandom_range(0, 7) == 0) ? 20'($urandom_range(1000000, 1048575))
				: 20'($urandom_range(0, 999999));
		if (steer) begin
			case (target)
				CLS_DPC:    d = 1'b1;
				CLS_USER:   begin d = 1'b0; u = 1'b1; end
				CLS_KERNEL: begin d = 1'b0; u = 1'b0; i = 1'b0; end
				default:    begin d = 1'b0; u = 1'b0; i = 1'b1; end
			endcase
			offer(FUNC_TICK, d, u, i, q, s, us);
		end else begin
			offer(($urandom_range(0, 9) == 0) ? FUNC_SET_TIME : FUNC_TICK, d, u, i, q, s, us);
		end
	endtask

	// receiver: stall pattern of its own, plus one long hold-off on request
	initial begin : receiver
		int mode;
		int len;
		int beat;
		out_stall = 1'b0;
		beat      = 0;
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(10, 80);
			repeat (len) begin
				@(negedge clk);
				beat++;
				if (hold_off_req) begin
					out_stall = 1'b1;
					repeat (HOLD_OFF_CYCLES) @(negedge clk);
					hold_off_req = 1'b0;
				end else begin
					case (mode)
						0: out_stall = 1'b0;
						1: out_stall = ($urandom_range(0, 3) == 0);
						2: out_stall = ($urandom_range(0, 1) == 0);
						default: out_stall = ((beat % 5) < 2);
					endcase
				end
			end
		end
	end

	// watchdog: cycles with no request or result moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		bit   steer;
		cls_t target;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		in_valid         = 1'b0;
		func             = FUNC_TICK;
		in_dpc           = 1'b0;
		user_mode        = 1'b0;
		idle_thread      = 1'b0;
		quantum_in       = '0;
		new_seconds      = '0;
		new_microseconds = '0;
		hold_off_req     = 1'b0;
		burst_left       = $urandom_range(1, 40);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset config: each class, precedence, quantum edges, wraps and carries
		offer(FUNC_TICK, 1'b0, 1'b0, 1'b0, 32'd100, 32'd0, 20'd0);
		offer(FUNC_TICK, 1'b0, 1'b1, 1'b0, 32'd50, 32'd0, 20'd0);
		offer(FUNC_TICK, 1'b1, 1'b1, 1'b1, 32'd1, 32'd0, 20'd0);
		offer(FUNC_TICK, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0, 20'd0);
		offer(FUNC_TICK, 1'b0, 1'b1, 1'b1, 32'h8000_0000, 32'd0, 20'd0);
		offer(FUNC_TICK, 1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'd0, 20'd0);
		offer(FUNC_SET_TIME, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd999999);
		offer(FUNC_TICK, 1'b0, 1'b0, 1'b0, 32'd2, 32'd0, 20'd0);
		offer(FUNC_SET_TIME, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 20'hFFFFF);
		offer(FUNC_TICK, 1'b0, 1'b1, 1'b0, 32'd9, 32'd0, 20'd0);
		offer(FUNC_TICK, 1'b0, 1'b0, 1'b1, 32'h8000_0001, 32'd0, 20'd0);

		// top of every register: double carry, saturation, preempt boundary
		configure(16'hFFFF, 20'd999999, 8'd255);
		offer(FUNC_SET_TIME, 1'b0, 1'b0, 1'b0, 32'd0, 32'd1234, 20'hFFFFF);
		offer(FUNC_TICK, 1'b0, 1'b0, 1'b0, 32'd1000, 32'd0, 20'd0);
		offer(FUNC_TICK, 1'b0, 1'b1, 1'b0, 32'h8000_0000, 32'd0, 20'd0);
		offer(FUNC_TICK, 1'b1, 1'b0, 1'b0, 32'd255, 32'd0, 20'd0);
		offer(FUNC_TICK, 1'b0, 1'b0, 1'b1, 32'd256, 32'd0, 20'd0);

		// bottom of every register: exact carry at one million
		configure(16'd0, 20'd1, 8'd1);
		offer(FUNC_TICK, 1'b1, 1'b0, 1'b1, 32'd7, 32'd0, 20'd0);
		offer(FUNC_TICK, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd0, 20'd0);
		offer(FUNC_SET_TIME, 1'b0, 1'b0, 1'b0, 32'd0, 32'd5, 20'd999999);
		offer(FUNC_TICK, 1'b0, 1'b0, 1'b0, 32'd3, 32'd0, 20'd0);

		// random phases; odd phases end with a full window of one class
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: configure(CLK_INC_RST, USEC_INC_RST, QUANTUM_PER_TICK_RST);
				3: configure(16'hFFFF, 20'd999999, 8'd255);
				5: configure(16'd0, 20'd1, 8'd1);
				default: configure(16'($urandom_range(0, 65535)),
						20'($urandom_range(1, 999999)), 8'($urandom_range(1, 255)));
			endcase
			target = cls_t'(p / 2);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				if (p == 2 && n == 60)
					hold_off_req = 1'b1;
				if (p == 4 && n == 100)
					drain();
				steer = (p % 2 == 1) && (n >= 90 || $urandom_range(0, 9) != 0);
				random_request(steer, target);
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/tcls_pkg.sv
hw/rtl/tcls_ram.sv
hw/rtl/tcls_front.sv
hw/rtl/tcls_fifo.sv
hw/rtl/tcls_back.sv
hw/rtl/tick_clock_and_load_sampler.sv
hw/rtl/tcls_checker.sv
verif/tick_clock_and_load_sampler_checker.sv
verif/tick_clock_and_load_sampler_tb.sv
